// ===== rtl/tle_pkg.sv =====
// shared types and character codes for the terminal line editor
package tle_pkg;

  typedef enum logic [2:0] {
    KIND_ECHO    = 3'd0,
    KIND_CHAR    = 3'd1,
    KIND_TERM    = 3'd2,
    KIND_NOLINE  = 3'd3,
    KIND_REFUSED = 3'd4
  } kind_e;

  typedef enum logic {
    OP_RECEIVE = 1'b0,
    OP_TAKE    = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_RD,
    S_OUT,
    S_TERM
  } state_e;

  typedef enum logic [2:0] {
    SEQ_CHAR,
    SEQ_CRLF,
    SEQ_RUBOUT,
    SEQ_REFUSED,
    SEQ_NOLINE
  } seq_e;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last;
  } out_t;

endpackage

// ===== rtl/terminal_line_editor.sv =====
// terminal line editor top level: line store, edit decode and result sequencing
//
//  channel  | signals                              | carries
//  ---------+--------------------------------------+------------------------------
//  in       | in_valid_i, in_ready_o, in_data_i    | operation and received byte
//  out      | out_valid_o, out_ready_i, out_data_o | kind, out byte, last flag
//  cfg      | cfg_we_i, cfg_wdata_i                | echo enable, written at once
//
// one transaction at a time: an input is taken only in the idle state
// edits are decided in the accept cycle; an echo then sends its bytes in order
// taking a line reads each character from the ram (S_RD), then outputs it (S_OUT),
// and ends with the terminator (S_TERM) once the last character is out
// a stalled output holds the sequencer; the output register frees the input side
// reset clears fill count, line ready, echo enable (to 1) and the output valid
module terminal_line_editor #(
  parameter int LINE_BYTES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tle_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tle_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);
  import tle_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);
  localparam int CW = $clog2(LINE_BYTES + 1);

  // control state
  state_e         state_q, state_d;
  seq_e           seq_q, seq_d;
  logic [1:0]     idx_q, idx_d;
  logic [7:0]     byte_q, byte_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic           ready_q, ready_d;
  logic [CW-1:0]  ptr_q, ptr_d;
  logic           echo_q;

  // output register
  out_t           out_q, out_d;
  logic           out_valid_q, out_valid_d;

  // ram ports
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [7:0]     ram_rdata;

  logic           accept;
  logic           slot_free;
  logic           is_end, is_rub;
  out_t           seq_item;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign is_end = (in_data_i.data_byte == CH_CR) || (in_data_i.data_byte == CH_LF);
  assign is_rub = (in_data_i.data_byte == CH_BS) || (in_data_i.data_byte == CH_DEL);

  tle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_BYTES)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ptr_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // the item an echo or status sequence shows at its current step
  always_comb begin
    seq_item = '{kind: KIND_ECHO, out_byte: 8'h00, last: 1'b1};
    case (seq_q)
      SEQ_CHAR: begin
        seq_item.out_byte = byte_q;
      end
      SEQ_CRLF: begin
        seq_item.out_byte = (idx_q == 2'd0) ? CH_CR : CH_LF;
        seq_item.last     = (idx_q == 2'd1);
      end
      SEQ_RUBOUT: begin
        seq_item.out_byte = (idx_q == 2'd1) ? CH_SP : CH_BS;
        seq_item.last     = (idx_q == 2'd2);
      end
      SEQ_REFUSED: begin
        seq_item.kind = KIND_REFUSED;
      end
      SEQ_NOLINE: begin
        seq_item.kind = KIND_NOLINE;
      end
      default: begin
        seq_item.kind = KIND_ECHO;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    seq_d       = seq_q;
    idx_d       = idx_q;
    byte_d      = byte_q;
    fill_d      = fill_q;
    ready_d     = ready_q;
    ptr_d       = ptr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = fill_q[AW-1:0];
    ram_wdata   = in_data_i.data_byte;
    ram_re      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d  = 2'd0;
          byte_d = in_data_i.data_byte;
          if (in_data_i.operation == OP_TAKE) begin
            ptr_d = '0;
            if (!ready_q || fill_q == '0) begin
              seq_d   = SEQ_NOLINE;
              state_d = S_EMIT;
            end else if (fill_q == CW'(1)) begin
              state_d = S_TERM;
            end else begin
              state_d = S_RD;
            end
          end else if (ready_q) begin
            // a line is waiting to be taken
            seq_d   = SEQ_REFUSED;
            state_d = S_EMIT;
          end else if (is_end) begin
            if (fill_q < CW'(LINE_BYTES)) begin
              ram_we    = 1'b1;
              ram_wdata = CH_LF;
              fill_d    = fill_q + CW'(1);
              ready_d   = 1'b1;
              seq_d     = SEQ_CRLF;
              if (echo_q) begin
                state_d = S_EMIT;
              end
            end
          end else if (is_rub) begin
            // no line end can be stored while no line is ready
            if (fill_q != '0) begin
              fill_d = fill_q - CW'(1);
              seq_d  = SEQ_RUBOUT;
              if (echo_q) begin
                state_d = S_EMIT;
              end
            end
          end else if (fill_q < CW'(LINE_BYTES - 1)) begin
            // one slot stays free for the line end
            ram_we = 1'b1;
            fill_d = fill_q + CW'(1);
            seq_d  = SEQ_CHAR;
            if (echo_q) begin
              state_d = S_EMIT;
            end
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_d       = seq_item;
          out_valid_d = 1'b1;
          idx_d       = idx_q + 2'd1;
          if (seq_item.last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          out_d       = '{kind: KIND_CHAR, out_byte: ram_rdata, last: 1'b0};
          out_valid_d = 1'b1;
          ptr_d       = ptr_q + CW'(1);
          // last character sits just below the stored line end
          if (ptr_q + CW'(2) == fill_q) begin
            state_d = S_TERM;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_TERM: begin
        if (slot_free) begin
          out_d       = '{kind: KIND_TERM, out_byte: 8'h00, last: 1'b1};
          out_valid_d = 1'b1;
          fill_d      = '0;
          ready_d     = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      ready_q     <= 1'b0;
      echo_q      <= 1'b1;
      out_valid_q <= 1'b0;
      seq_q       <= SEQ_CHAR;
      idx_q       <= 2'd0;
      ptr_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      seq_q       <= seq_d;
      idx_q       <= idx_d;
      ptr_q       <= ptr_d;
      if (cfg_we_i) begin
        echo_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    out_q  <= out_d;
  end

endmodule

// ===== rtl/tle_ram.sv =====
// generic single-clock ram, one write port, one registered read port
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
